>>> rtl/wblc_pkg.sv
// Package for the write-back LRU data cache: geometry constants, codes,
// item structs and the command and status structs between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
package wblc_pkg;
   localparam int NUM_SETS      = 256;
   localparam int NUM_WAYS      = 8;
   localparam int LINE_BYTES    = 32;
   localparam int TAG_BITS      = 7;
   localparam int WORDS         = LINE_BYTES / 4;
   localparam int OFFSET_BITS   = $clog2(LINE_BYTES);
   localparam int SET_BITS      = $clog2(NUM_SETS);
   localparam int WORD_BITS     = $clog2(WORDS);
   localparam int WAY_BITS      = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int AGE_BITS      = WAY_BITS;
   localparam int TAG_SHIFT     = OFFSET_BITS + SET_BITS;
   localparam int CNT_BITS      = (SET_BITS > WORD_BITS) ? SET_BITS : WORD_BITS;
   localparam int DATA_ADDR_BITS = SET_BITS + WAY_BITS + WORD_BITS;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [1:0] FUNC_READ   = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_FILL   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [2:0] KIND_READ   = 3'd0;
   localparam logic [2:0] KIND_WRITE  = 3'd1;
   localparam logic [2:0] KIND_WB     = 3'd2;
   localparam logic [2:0] KIND_REQ    = 3'd3;
   localparam logic [2:0] KIND_REJECT = 3'd4;

   localparam logic [31:0] BASE_RESET = 32'h1000_0000;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] address;
      logic [31:0] write_data;
      logic [31:0] fill_data;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] data;
      logic [31:0] mem_address;
      logic        was_hit;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic                valid;
      logic                dirty;
      logic [AGE_BITS-1:0] age;
   } way_meta_type;

   typedef way_meta_type [NUM_WAYS-1:0] meta_row_type;

   typedef struct packed {
      logic                accept;
      logic                clear;
      logic [SET_BITS-1:0] clear_idx;
      logic                hit_upd;
      logic                miss_start;
      logic                fill;
      logic                fin;
      logic                wb_rd;
      logic [WORD_BITS-1:0] wb_idx;
      logic                emit;
      logic [2:0]          kind;
      logic                hit;
      logic                last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       pending;
      logic       hit;
      logic       victim_dirty;
      logic       fill_last;
      logic       pend_write;
   } status_type;
endpackage

>>> rtl/wblc_datapath.sv
// Datapath of the write-back LRU data cache: tag/state and word memories,
// hit and victim logic, pending miss registers and the configuration register.
// Depends on wblc_pkg.
`timescale 1ns / 1ps
module wblc_datapath import wblc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  req_item_type             req_item,
   output rsp_item_type             rsp_item,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata
);
   meta_row_type        meta_mem [NUM_SETS];
   logic [31:0]         data_mem [NUM_SETS*NUM_WAYS*WORDS];

   logic [31:0]         base_ff;
   logic [1:0]          func_ff;
   logic [31:0]         addr_ff;
   logic [31:0]         wdata_ff;
   logic [31:0]         fdata_ff;
   logic [SET_BITS-1:0] set_ff;
   logic                pend_ff;
   logic                pend_write_ff;
   logic [31:0]         pend_addr_ff;
   logic [31:0]         pend_wdata_ff;
   logic [WAY_BITS-1:0] pend_way_ff;
   logic [WORD_BITS-1:0] fill_cnt_ff;
   logic [31:0]         wb_base_ff;
   logic [WORD_BITS-1:0] rd_word_ff;
   meta_row_type        meta_rd_ff;
   logic [31:0]         data_rd_ff;

   logic                hit;
   logic [WAY_BITS-1:0] hit_way;
   logic [WAY_BITS-1:0] victim_way;
   logic                meta_we;
   logic [SET_BITS-1:0] meta_wa;
   meta_row_type        meta_wd;
   logic                data_we;
   logic                data_re;
   logic [DATA_ADDR_BITS-1:0] data_a;
   logic [31:0]         data_wd;
   logic [WORD_BITS-1:0] data_word;
   logic [SET_BITS-1:0] pend_set;
   logic [SET_BITS-1:0] lookup_set;

   function automatic meta_row_type age_row(meta_row_type row, logic [WAY_BITS-1:0] way,
                                            logic [AGE_BITS:0] thr);
      meta_row_type r;
      r = row;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (WAY_BITS'(w) != way && row[w].valid && {1'b0, row[w].age} < thr &&
             row[w].age != AGE_BITS'(NUM_WAYS - 1)) begin
            r[w].age = row[w].age + 1'b1;
         end
      end
      r[way].age = '0;
      return r;
   endfunction

   assign pend_set   = pend_addr_ff[OFFSET_BITS +: SET_BITS];
   assign lookup_set = (req_item.func == FUNC_FILL) ? pend_set
                                                    : req_item.address[OFFSET_BITS +: SET_BITS];

   always_comb begin
      hit        = 1'b0;
      hit_way    = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (meta_rd_ff[w].valid && meta_rd_ff[w].tag == addr_ff[TAG_SHIFT +: TAG_BITS]) begin
            hit     = 1'b1;
            hit_way = WAY_BITS'(w);
         end
      end
   end

   always_comb begin
      logic found;
      found      = 1'b0;
      victim_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (!meta_rd_ff[w].valid) begin
            found      = 1'b1;
            victim_way = WAY_BITS'(w);
         end
      end
      if (!found) begin
         for (int w = 1; w < NUM_WAYS; w++) begin
            if (meta_rd_ff[w].age > meta_rd_ff[victim_way].age) begin
               victim_way = WAY_BITS'(w);
            end
         end
      end
   end

   always_comb begin
      meta_row_type row;
      row     = meta_rd_ff;
      meta_we = 1'b0;
      meta_wa = set_ff;
      meta_wd = meta_rd_ff;
      if (cmd.clear) begin
         meta_we = 1'b1;
         meta_wa = cmd.clear_idx;
         meta_wd = '0;
      end else if (cmd.hit_upd) begin
         row = age_row(meta_rd_ff, hit_way, {1'b0, meta_rd_ff[hit_way].age});
         if (func_ff == FUNC_WRITE) begin
            row[hit_way].dirty = 1'b1;
         end
         meta_we = 1'b1;
         meta_wd = row;
      end else if (cmd.fill && status.fill_last) begin
         row = age_row(meta_rd_ff, pend_way_ff,
                       meta_rd_ff[pend_way_ff].valid ? {1'b0, meta_rd_ff[pend_way_ff].age}
                                                     : (AGE_BITS + 1)'(NUM_WAYS));
         row[pend_way_ff].tag   = pend_addr_ff[TAG_SHIFT +: TAG_BITS];
         row[pend_way_ff].valid = 1'b1;
         row[pend_way_ff].dirty = pend_write_ff;
         meta_we = 1'b1;
         meta_wd = row;
      end
   end

   always_comb begin
      data_we   = 1'b0;
      data_re   = 1'b0;
      data_word = addr_ff[2 +: WORD_BITS];
      data_a    = {set_ff, hit_way, addr_ff[2 +: WORD_BITS]};
      data_wd   = wdata_ff;
      if (cmd.hit_upd) begin
         data_we = (func_ff == FUNC_WRITE);
         data_re = (func_ff != FUNC_WRITE);
      end else if (cmd.fill) begin
         data_we = 1'b1;
         data_a  = {set_ff, pend_way_ff, fill_cnt_ff};
         data_wd = fdata_ff;
      end else if (cmd.fin) begin
         data_word = pend_addr_ff[2 +: WORD_BITS];
         data_we   = pend_write_ff;
         data_re   = !pend_write_ff;
         data_a    = {pend_set, pend_way_ff, pend_addr_ff[2 +: WORD_BITS]};
         data_wd   = pend_wdata_ff;
      end else if (cmd.wb_rd) begin
         data_word = cmd.wb_idx;
         data_re   = 1'b1;
         data_a    = {pend_set, pend_way_ff, cmd.wb_idx};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         meta_rd_ff <= meta_mem[lookup_set];
      end
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      if (data_we) begin
         data_mem[data_a] <= data_wd;
      end
      if (data_re) begin
         data_rd_ff <= data_mem[data_a];
         rd_word_ff <= data_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff  <= req_item.func;
         addr_ff  <= req_item.address;
         wdata_ff <= req_item.write_data;
         fdata_ff <= req_item.fill_data;
         set_ff   <= lookup_set;
      end
      if (cmd.miss_start) begin
         pend_write_ff <= (func_ff == FUNC_WRITE);
         pend_addr_ff  <= addr_ff;
         pend_wdata_ff <= wdata_ff;
         pend_way_ff   <= victim_way;
         wb_base_ff    <= ((32'(meta_rd_ff[victim_way].tag) << TAG_SHIFT) |
                           (32'(set_ff) << OFFSET_BITS)) | base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= 1'b0;
         fill_cnt_ff <= '0;
         base_ff     <= BASE_RESET;
      end else begin
         if (cmd.miss_start) begin
            pend_ff     <= 1'b1;
            fill_cnt_ff <= '0;
         end else if (cmd.fill) begin
            fill_cnt_ff <= fill_cnt_ff + 1'b1;
         end
         if (cmd.fin) begin
            pend_ff <= 1'b0;
         end
         if (psel && penable && pwrite && !paddr[CSR_ADDR_BITS-1]) begin
            base_ff <= pwdata;
         end
      end
   end

   assign prdata = paddr[CSR_ADDR_BITS-1] ? 32'd0 : base_ff;

   assign status.func         = func_ff;
   assign status.pending      = pend_ff;
   assign status.hit          = hit;
   assign status.victim_dirty = meta_rd_ff[victim_way].valid && meta_rd_ff[victim_way].dirty;
   assign status.fill_last    = (fill_cnt_ff == WORD_BITS'(WORDS - 1));
   assign status.pend_write   = pend_write_ff;

   assign rsp_item.kind    = cmd.kind;
   assign rsp_item.was_hit = cmd.hit;
   assign rsp_item.last    = cmd.last;
   assign rsp_item.data    = (cmd.emit && (cmd.kind == KIND_READ || cmd.kind == KIND_WB))
                             ? data_rd_ff : 32'd0;
   assign rsp_item.mem_address =
      (cmd.kind == KIND_WB)  ? wb_base_ff + 32'({rd_word_ff, 2'b00}) :
      (cmd.kind == KIND_REQ) ? (pend_addr_ff & ~32'(LINE_BYTES - 1)) : 32'd0;
endmodule

>>> rtl/wblc_controller.sv
// Controller of the write-back LRU data cache: clearing pass, lookup,
// writeback, line request and fill sequencing.
// Depends on wblc_pkg.
`timescale 1ns / 1ps
module wblc_controller import wblc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);
   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_LOOK    = 4'd2;
   localparam logic [3:0] S_RD_HIT  = 4'd3;
   localparam logic [3:0] S_RD_MISS = 4'd4;
   localparam logic [3:0] S_FIN     = 4'd5;
   localparam logic [3:0] S_WB      = 4'd6;
   localparam logic [3:0] S_WB_END  = 4'd7;
   localparam logic [3:0] S_REQ     = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                reject;

   assign busy   = (state_ff != S_IDLE);
   assign reject = (status.func == FUNC_UNUSED) ||
                   (status.func != FUNC_FILL && status.pending) ||
                   (status.func == FUNC_FILL && !status.pending);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.clear_idx = cnt_ff[SET_BITS-1:0];
      cmd.wb_idx    = cnt_ff[WORD_BITS-1:0];
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff[SET_BITS-1:0] == SET_BITS'(NUM_SETS - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_IDLE;
            if (reject) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_REJECT;
               cmd.last = 1'b1;
            end else if (status.func == FUNC_FILL) begin
               cmd.fill = 1'b1;
               if (status.fill_last) begin
                  state_in = S_FIN;
               end
            end else if (status.hit) begin
               cmd.hit_upd = 1'b1;
               if (status.func == FUNC_WRITE) begin
                  cmd.emit = 1'b1;
                  cmd.kind = KIND_WRITE;
                  cmd.hit  = 1'b1;
                  cmd.last = 1'b1;
               end else begin
                  state_in = S_RD_HIT;
               end
            end else begin
               cmd.miss_start = 1'b1;
               cnt_in         = '0;
               state_in       = status.victim_dirty ? S_WB : S_REQ;
            end
         end
         S_RD_HIT: begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_READ;
            cmd.hit  = 1'b1;
            cmd.last = 1'b1;
            state_in = S_IDLE;
         end
         S_RD_MISS: begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_READ;
            cmd.last = 1'b1;
            state_in = S_IDLE;
         end
         S_FIN: begin
            cmd.fin = 1'b1;
            if (status.pend_write) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_WRITE;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_RD_MISS;
            end
         end
         S_WB: begin
            cmd.wb_rd = 1'b1;
            cmd.kind  = KIND_WB;
            cmd.emit  = (cnt_ff[WORD_BITS-1:0] != '0);
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff[WORD_BITS-1:0] == WORD_BITS'(WORDS - 1)) begin
               cnt_in   = '0;
               state_in = S_WB_END;
            end
         end
         S_WB_END: begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_WB;
            state_in = S_REQ;
         end
         S_REQ: begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_REQ;
            cmd.last = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == S_LOOK) else $error("accepted item not looked up");
   a_req_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REQ |=> state_ff == S_IDLE) else $error("line request not final");
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> state_ff != S_IDLE && state_ff != S_CLEAR) else $error("result while idle");
`endif
endmodule

>>> rtl/write_back_lru_data_cache.sv
// Top level of the write-back LRU data cache.
// Depends on wblc_pkg, wblc_controller and wblc_datapath.
`timescale 1ns / 1ps
// After reset the cache clears the line state of every set with busy high.
// Each item is taken when start is high and busy is low; results come one per
// cycle on rsp_strobe and cannot be held off. Every item is looked up after
// its set's tag row is read; a hit read then reads the word memory, the final
// fill word finishes the pending access (a read adds a word read), and a miss
// writes back a dirty victim line before the line request.
module write_back_lru_data_cache import wblc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_item_type             req_item,
   output logic                     rsp_strobe,
   output rsp_item_type             rsp_item,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   cmd_type    cmd;
   status_type status;

   assign pready     = 1'b1;
   assign rsp_strobe = cmd.emit;

   wblc_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   wblc_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_item (req_item),
      .rsp_item (rsp_item),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata)
   );
endmodule
